/* hw/rtl/csm_pkg.sv */
// Package for the circle span mask: input and result word types,
// register indexes and item kind codes. No dependencies.

package csm_pkg;

  localparam int RadiusW = 8;
  localparam int CoordW  = 16;

  typedef enum logic [1:0] {
    CFG_RADIUS   = 2'd0,
    CFG_CENTER_X = 2'd1,
    CFG_TOP_ROW  = 2'd2
  } cfg_index_t;

  typedef enum logic {
    KIND_REBUILD = 1'b0,
    KIND_QUERY   = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
  } item_t;

  typedef struct packed {
    logic searchable;
    logic row_outside;
  } result_t;

endpackage

/* hw/rtl/circle_span_mask.sv */
// Circle span mask top level: half-width table memory, rebuild sequencer
// and two-stage query path. Depends on csm_pkg.
//
//   channel  | signals                                  | handshake
//   ---------+------------------------------------------+-------------------------
//   item     | start, busy, item                        | taken when start & !busy
//   result   | done, result                             | one cycle, no stall
//   config   | cfg_valid, cfg_ready, cfg_index, cfg_data| taken when valid & ready
//
// A query word's result is registered through the p1 stage and then into
// result and done; queries may be issued every cycle while busy is low.
// A rebuild word writes table rows 0..2r in turn, each once its half-width
// settles, with busy high throughout; its result follows the last write.
// Reset is synchronous and marks the table empty; no clearing pass is run.

module circle_span_mask #(
  parameter int MAX_RADIUS = 255
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  csm_pkg::item_t            item,
  output logic                      done,
  output csm_pkg::result_t          result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [csm_pkg::CoordW-1:0] cfg_data
);
  import csm_pkg::*;

  localparam int Depth = 2 * MAX_RADIUS + 1;
  localparam int RowW  = $clog2(Depth);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_BUILD = 2'b10
  } state_t;

  state_t state, state_next;

  logic [RadiusW-1:0] radius;
  logic [CoordW-1:0]  center_x;
  logic [CoordW-1:0]  top_row;

  logic [RadiusW-1:0] span_mem [Depth];
  logic [RadiusW-1:0] rd_data;

  logic               built;
  logic [RowW-1:0]    built_last;

  logic [RowW-1:0]    b_row;
  logic [RowW-1:0]    b_last;
  logic [RadiusW-1:0] b_r;
  logic [RadiusW-1:0] dy;
  logic [CoordW-1:0]  room;
  logic [RadiusW-1:0] h;
  logic [CoordW-1:0]  hsq;

  logic               p1_valid;
  logic               p1_outside;
  logic               p1_use;
  logic [CoordW-1:0]  p1_px;

  logic [RadiusW-1:0] eff_r;
  logic               accept;
  logic [CoordW-1:0]  q_row;
  logic               q_outside;
  logic               q_use;
  logic [RowW-1:0]    q_addr;

  logic [CoordW:0]    sq_up;
  logic               up_ok;
  logic               down_need;
  logic               wr_en;
  logic               at_last;
  logic               going_up;
  logic               build_finish;
  logic               hit;

  assign cfg_ready = 1'b1;
  assign busy      = (state == S_BUILD);
  assign accept    = start && !busy;

  assign eff_r = (int'(radius) > MAX_RADIUS) ? RadiusW'(MAX_RADIUS) : radius;

  assign q_row     = item.pixel_y - top_row;
  assign q_outside = (item.pixel_y < top_row) ||
                     (q_row > {{(CoordW-RadiusW-1){1'b0}}, eff_r, 1'b0});
  assign q_use     = built && (q_row <= CoordW'(built_last));
  assign q_addr    = q_row[RowW-1:0];

  assign sq_up     = {1'b0, hsq} + (CoordW+1)'({h, 1'b0}) + (CoordW+1)'(1);
  assign up_ok     = sq_up <= {1'b0, room};
  assign down_need = hsq > room;
  assign wr_en     = (state == S_BUILD) && !up_ok && !down_need;
  assign at_last   = (b_row == b_last);
  assign going_up  = CoordW'(b_row) < CoordW'(b_r);
  assign build_finish = wr_en && at_last;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && item.kind == KIND_REBUILD) state_next = S_BUILD;
      end
      S_BUILD: begin
        if (build_finish) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      span_mem[b_row] <= h;
    end
    rd_data <= span_mem[q_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius   <= '0;
      center_x <= '0;
      top_row  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RADIUS:   radius   <= cfg_data[RadiusW-1:0];
        CFG_CENTER_X: center_x <= cfg_data;
        CFG_TOP_ROW:  top_row  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      built      <= 1'b0;
      built_last <= '0;
    end else begin
      state <= state_next;
      if (accept && item.kind == KIND_REBUILD) begin
        built      <= 1'b1;
        built_last <= RowW'({eff_r, 1'b0});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.kind == KIND_REBUILD) begin
      b_row  <= '0;
      b_last <= RowW'({eff_r, 1'b0});
      b_r    <= eff_r;
      dy     <= eff_r;
      room   <= '0;
      h      <= '0;
      hsq    <= '0;
    end else if (state == S_BUILD) begin
      if (up_ok) begin
        h   <= h + RadiusW'(1);
        hsq <= sq_up[CoordW-1:0];
      end else if (down_need) begin
        h   <= h - RadiusW'(1);
        hsq <= hsq - CoordW'({h, 1'b0}) + CoordW'(1);
      end else if (!at_last) begin
        b_row <= b_row + RowW'(1);
        if (going_up) begin
          dy   <= dy - RadiusW'(1);
          room <= room + CoordW'({dy, 1'b0}) - CoordW'(1);
        end else begin
          dy   <= dy + RadiusW'(1);
          room <= room - CoordW'({dy, 1'b0}) - CoordW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= accept && item.kind == KIND_QUERY;
    end
    p1_outside <= q_outside;
    p1_use     <= q_use && !q_outside;
    p1_px      <= item.pixel_x;
  end

  assign hit = p1_use && (rd_data != '0) &&
               ({1'b0, p1_px} + (CoordW+1)'(rd_data) >= {1'b0, center_x}) &&
               ({1'b0, p1_px} <= {1'b0, center_x} + (CoordW+1)'(rd_data));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p1_valid || build_finish;
    end
    priority if (p1_valid) begin
      result.searchable  <= hit;
      result.row_outside <= p1_outside;
    end else begin
      result.searchable  <= 1'b0;
      result.row_outside <= 1'b0;
    end
  end

endmodule
